>>> sv/aarm_pkg.sv
// Shared types, constants and helpers for the axis-angle rotation matrix core.
// Standalone package; used by the CORDIC cell, the entry unit and the top level.
`default_nettype none

package aarm_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned FRAC_BITS_DEF    = 14;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam int FIELD_W   = 16;
  localparam int UV_W      = 2 * FIELD_W;
  localparam int FIELD_MAX = 32767;
  localparam int FIELD_MIN = -32768;

  // Angle in 1/64 degree
  localparam int ANGLE_FULL    = 23040;
  localparam int ANGLE_HALF    = 11520;
  localparam int ANGLE_QUARTER = 5760;

  // CORDIC datapath: x/y with 30 fraction bits, z in 2^-22 degree
  localparam int CORDIC_FRAC = 30;
  localparam int CORDIC_GAIN = 652032874;
  localparam int CORDIC_W    = 34;
  localparam int ANGLE_W     = 32;
  localparam int Z_SHIFT     = 16;
  localparam int ATAN_LEN    = 32;
  localparam int ATAN_IDX_W  = $clog2(ATAN_LEN);

  typedef struct packed {
    logic signed [FIELD_W-1:0] angle;
    logic signed [FIELD_W-1:0] axis_x;
    logic signed [FIELD_W-1:0] axis_y;
    logic signed [FIELD_W-1:0] axis_z;
  } req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] entry0;
    logic signed [FIELD_W-1:0] entry1;
    logic signed [FIELD_W-1:0] entry2;
    logic signed [FIELD_W-1:0] entry3;
    logic signed [FIELD_W-1:0] entry4;
    logic signed [FIELD_W-1:0] entry5;
    logic signed [FIELD_W-1:0] entry6;
    logic signed [FIELD_W-1:0] entry7;
    logic signed [FIELD_W-1:0] entry8;
  } rsp_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [ANGLE_W-1:0]  z;
  } cordic_t;

  // Axis and quadrant fold flag ride along with the rotation
  typedef struct packed {
    logic signed [FIELD_W-1:0] axis_x;
    logic signed [FIELD_W-1:0] axis_y;
    logic signed [FIELD_W-1:0] axis_z;
    logic                      neg;
  } side_t;

  // Width of c, s and t
  function automatic int cs_width(input int frac);
    return frac + 3;
  endfunction

  // Width of t*u*v
  function automatic int prod_width(input int frac);
    return frac + 3 + UV_W;
  endfunction

  // Width of the exact terms c<<frac and s*u
  function automatic int base_width(input int frac);
    return (2 * frac + 3 > frac + 3 + FIELD_W) ? 2 * frac + 3 : frac + 3 + FIELD_W;
  endfunction

  // atan(2^-i) in degrees, scaled by 2^22
  function automatic logic signed [ANGLE_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANGLE_W-1:0] v;
    case (idx)
      5'd0:    v = 32'sd188743680;
      5'd1:    v = 32'sd111421900;
      5'd2:    v = 32'sd58872272;
      5'd3:    v = 32'sd29884485;
      5'd4:    v = 32'sd15000234;
      5'd5:    v = 32'sd7507429;
      5'd6:    v = 32'sd3754631;
      5'd7:    v = 32'sd1877430;
      5'd8:    v = 32'sd938729;
      5'd9:    v = 32'sd469366;
      5'd10:   v = 32'sd234683;
      5'd11:   v = 32'sd117342;
      5'd12:   v = 32'sd58671;
      5'd13:   v = 32'sd29335;
      5'd14:   v = 32'sd14668;
      5'd15:   v = 32'sd7334;
      5'd16:   v = 32'sd3667;
      5'd17:   v = 32'sd1833;
      5'd18:   v = 32'sd917;
      5'd19:   v = 32'sd458;
      5'd20:   v = 32'sd229;
      5'd21:   v = 32'sd115;
      5'd22:   v = 32'sd57;
      5'd23:   v = 32'sd29;
      5'd24:   v = 32'sd14;
      5'd25:   v = 32'sd7;
      5'd26:   v = 32'sd4;
      5'd27:   v = 32'sd2;
      5'd28:   v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> sv/axis_angle_rotation_matrix_core.sv
// Rodrigues rotation matrix from angle and axis: angle fold, CORDIC chain,
// product stages and nine entry units. Depends on aarm_pkg, aarm_cordic_cell, aarm_entry.
//
//   channel   direction  handshake               word
//   request   in         start_i, busy_o         req_i (angle, axis_x/y/z)
//   result    out        valid_o strobe          rsp_o (entry0..entry8)
//
// One word accepted per cycle; busy_o stays low, the chain is fully pipelined.
// The pipeline runs through the fold register, one cell per CORDIC step, c/s/t and
// axis products, t*u*v products, then three stages in each entry unit.
// Reset clears only the valid bits of the pipeline; words in flight are dropped.
// The result is shown for one cycle with valid_o and cannot be held off.
`default_nettype none

module axis_angle_rotation_matrix_core #(
  parameter int unsigned FRAC_BITS    = aarm_pkg::FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  output logic               busy_o,
  input  aarm_pkg::req_t     req_i,
  output logic               valid_o,
  output aarm_pkg::rsp_t     rsp_o
);

  localparam int CS_W   = aarm_pkg::cs_width(FRAC_BITS);
  localparam int SU_W   = CS_W + aarm_pkg::FIELD_W;
  localparam int CW_W   = 2 * FRAC_BITS + 3;
  localparam int PROD_W = aarm_pkg::prod_width(FRAC_BITS);
  localparam int BASE_W = aarm_pkg::base_width(FRAC_BITS);
  localparam int SH     = aarm_pkg::CORDIC_FRAC - FRAC_BITS;
  localparam int LAT    = CORDIC_STEPS + 6;

  localparam logic signed [aarm_pkg::CORDIC_W-1:0] C_HALF =
    (aarm_pkg::CORDIC_W'(1) << SH) >> 1;
  localparam logic signed [CS_W-1:0] T_ONE = CS_W'(1) << FRAC_BITS;
  localparam logic signed [aarm_pkg::ANGLE_W-1:0] Z_MAX =
    aarm_pkg::ANGLE_W'(aarm_pkg::ANGLE_QUARTER) <<< aarm_pkg::Z_SHIFT;
  // entries whose sine term is subtracted: 1, 5 and 6
  localparam logic [8:0] ENTRY_SUB = 9'b001100010;

  // ---------------- angle fold ----------------
  logic signed [16:0] ang_w, ang_f1, ang_f2;
  logic               fold_neg;
  logic               s0_valid_q;
  aarm_pkg::cordic_t  s0_cor_d, s0_cor_q;
  aarm_pkg::side_t    s0_side_d, s0_side_q;

  assign busy_o = 1'b0;
  assign ang_w  = 17'(req_i.angle);

  always_comb begin
    if (ang_w >= 17'sd11520) begin
      ang_f1 = ang_w - 17'(aarm_pkg::ANGLE_FULL);
    end else if (ang_w < -17'sd11520) begin
      ang_f1 = ang_w + 17'(aarm_pkg::ANGLE_FULL);
    end else begin
      ang_f1 = ang_w;
    end
    // beyond +-90 degrees: turn by 180 and negate the result
    fold_neg = 1'b1;
    if (ang_f1 > 17'(aarm_pkg::ANGLE_QUARTER)) begin
      ang_f2 = ang_f1 - 17'(aarm_pkg::ANGLE_HALF);
    end else if (ang_f1 < -17'(aarm_pkg::ANGLE_QUARTER)) begin
      ang_f2 = ang_f1 + 17'(aarm_pkg::ANGLE_HALF);
    end else begin
      ang_f2   = ang_f1;
      fold_neg = 1'b0;
    end
    s0_cor_d.x       = aarm_pkg::CORDIC_W'(aarm_pkg::CORDIC_GAIN);
    s0_cor_d.y       = '0;
    s0_cor_d.z       = {ang_f2[aarm_pkg::ANGLE_W-aarm_pkg::Z_SHIFT-1:0],
                        {aarm_pkg::Z_SHIFT{1'b0}}};
    s0_side_d.axis_x = req_i.axis_x;
    s0_side_d.axis_y = req_i.axis_y;
    s0_side_d.axis_z = req_i.axis_z;
    s0_side_d.neg    = fold_neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_cor_q  <= s0_cor_d;
    s0_side_q <= s0_side_d;
  end

  // ---------------- CORDIC chain ----------------
  logic              cel_valid [0:CORDIC_STEPS];
  aarm_pkg::cordic_t cel_cor   [0:CORDIC_STEPS];
  aarm_pkg::side_t   cel_side  [0:CORDIC_STEPS];

  assign cel_valid[0] = s0_valid_q;
  assign cel_cor[0]   = s0_cor_q;
  assign cel_side[0]  = s0_side_q;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    aarm_cordic_cell #(
      .STEP (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cel_valid[g]),
      .cor_i   (cel_cor[g]),
      .side_i  (cel_side[g]),
      .valid_o (cel_valid[g+1]),
      .cor_o   (cel_cor[g+1]),
      .side_o  (cel_side[g+1])
    );
  end

  // ---------------- c, s, t and axis products ----------------
  logic signed [aarm_pkg::CORDIC_W-1:0] xn, yn;
  logic signed [aarm_pkg::FIELD_W-1:0]  ax, ay, az;
  logic signed [CS_W-1:0]               p1_c_d, p1_s_d, p1_t_d, p1_c_q, p1_s_q, p1_t_q;
  logic signed [aarm_pkg::UV_W-1:0]     p1_uv_d [0:5];
  logic signed [aarm_pkg::UV_W-1:0]     p1_uv_q [0:5];
  logic signed [aarm_pkg::FIELD_W-1:0]  p1_ax_q, p1_ay_q, p1_az_q;
  logic                                 p1_valid_q;

  always_comb begin
    ax = cel_side[CORDIC_STEPS].axis_x;
    ay = cel_side[CORDIC_STEPS].axis_y;
    az = cel_side[CORDIC_STEPS].axis_z;
    if (cel_side[CORDIC_STEPS].neg) begin
      xn = -cel_cor[CORDIC_STEPS].x;
      yn = -cel_cor[CORDIC_STEPS].y;
    end else begin
      xn = cel_cor[CORDIC_STEPS].x;
      yn = cel_cor[CORDIC_STEPS].y;
    end
    p1_c_d     = CS_W'((xn + C_HALF) >>> SH);
    p1_s_d     = CS_W'((yn + C_HALF) >>> SH);
    p1_t_d     = T_ONE - p1_c_d;
    p1_uv_d[0] = ax * ax;
    p1_uv_d[1] = ax * ay;
    p1_uv_d[2] = ax * az;
    p1_uv_d[3] = ay * ay;
    p1_uv_d[4] = ay * az;
    p1_uv_d[5] = az * az;
  end

  always_ff @(posedge clk_i) begin
    p1_c_q  <= p1_c_d;
    p1_s_q  <= p1_s_d;
    p1_t_q  <= p1_t_d;
    p1_uv_q <= p1_uv_d;
    p1_ax_q <= ax;
    p1_ay_q <= ay;
    p1_az_q <= az;
  end

  // ---------------- t*u*v, s*u, c<<frac ----------------
  logic signed [PROD_W-1:0] p2_tuv_d [0:5];
  logic signed [PROD_W-1:0] p2_tuv_q [0:5];
  logic signed [SU_W-1:0]   p2_sx_q, p2_sy_q, p2_sz_q;
  logic signed [CW_W-1:0]   p2_cw_q;
  logic                     p2_valid_q;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      p2_tuv_d[k] = p1_t_q * p1_uv_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    p2_tuv_q <= p2_tuv_d;
    p2_sx_q  <= p1_s_q * p1_ax_q;
    p2_sy_q  <= p1_s_q * p1_ay_q;
    p2_sz_q  <= p1_s_q * p1_az_q;
    p2_cw_q  <= CW_W'(p1_c_q) <<< FRAC_BITS;
  end

  // ---------------- entry units ----------------
  logic signed [BASE_W-1:0]           ent_base [0:8];
  logic signed [PROD_W-1:0]           ent_prod [0:8];
  logic signed [aarm_pkg::FIELD_W-1:0] ent_out [0:8];
  logic [2:0]                         e_valid_q;

  always_comb begin
    ent_base[0] = BASE_W'(p2_cw_q);
    ent_base[1] = BASE_W'(p2_sz_q);
    ent_base[2] = BASE_W'(p2_sy_q);
    ent_base[3] = BASE_W'(p2_sz_q);
    ent_base[4] = BASE_W'(p2_cw_q);
    ent_base[5] = BASE_W'(p2_sx_q);
    ent_base[6] = BASE_W'(p2_sy_q);
    ent_base[7] = BASE_W'(p2_sx_q);
    ent_base[8] = BASE_W'(p2_cw_q);
    ent_prod[0] = p2_tuv_q[0];
    ent_prod[1] = p2_tuv_q[1];
    ent_prod[2] = p2_tuv_q[2];
    ent_prod[3] = p2_tuv_q[1];
    ent_prod[4] = p2_tuv_q[3];
    ent_prod[5] = p2_tuv_q[4];
    ent_prod[6] = p2_tuv_q[2];
    ent_prod[7] = p2_tuv_q[4];
    ent_prod[8] = p2_tuv_q[5];
  end

  for (genvar e = 0; e < 9; e++) begin : g_entry
    aarm_entry #(
      .FRAC_BITS (FRAC_BITS),
      .SUBTRACT  (ENTRY_SUB[e])
    ) u_entry (
      .clk_i   (clk_i),
      .base_i  (ent_base[e]),
      .prod_i  (ent_prod[e]),
      .entry_o (ent_out[e])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      e_valid_q  <= '0;
    end else begin
      p1_valid_q <= cel_valid[CORDIC_STEPS];
      p2_valid_q <= p1_valid_q;
      e_valid_q  <= {e_valid_q[1:0], p2_valid_q};
    end
  end

  assign valid_o      = e_valid_q[2];
  assign rsp_o.entry0 = ent_out[0];
  assign rsp_o.entry1 = ent_out[1];
  assign rsp_o.entry2 = ent_out[2];
  assign rsp_o.entry3 = ent_out[3];
  assign rsp_o.entry4 = ent_out[4];
  assign rsp_o.entry5 = ent_out[5];
  assign rsp_o.entry6 = ent_out[6];
  assign rsp_o.entry7 = ent_out[7];
  assign rsp_o.entry8 = ent_out[8];

  // ---------------- assertions ----------------
  // a result only comes out for a word that was taken earlier
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without matching request");

  // folded angle stays within +-90 degrees
  a_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q |-> (s0_cor_q.z <= Z_MAX) && (s0_cor_q.z >= -Z_MAX))
    else $error("angle fold out of range");

  // zero axis leaves only the cosine on the diagonal
  a_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(req_i.axis_x == '0 && req_i.axis_y == '0 &&
                     req_i.axis_z == '0, LAT)
    |-> rsp_o.entry1 == '0 && rsp_o.entry2 == '0 && rsp_o.entry3 == '0 &&
        rsp_o.entry5 == '0 && rsp_o.entry6 == '0 && rsp_o.entry7 == '0)
    else $error("off-diagonal nonzero for zero axis");

  a_zero_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(req_i.axis_x == '0 && req_i.axis_y == '0 &&
                     req_i.axis_z == '0, LAT)
    |-> rsp_o.entry0 == rsp_o.entry4 && rsp_o.entry4 == rsp_o.entry8)
    else $error("diagonal mismatch for zero axis");

endmodule

`default_nettype wire

>>> sv/aarm_cordic_cell.sv
// One rotation step of the CORDIC chain, registered.
// Depends on aarm_pkg (cordic_t, side_t, atan_deg).
`default_nettype none

module aarm_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    valid_i,
  input  aarm_pkg::cordic_t      cor_i,
  input  aarm_pkg::side_t        side_i,
  output logic                   valid_o,
  output aarm_pkg::cordic_t      cor_o,
  output aarm_pkg::side_t        side_o
);

  logic signed [aarm_pkg::CORDIC_W-1:0] x_in, y_in, dx, dy;
  logic signed [aarm_pkg::ANGLE_W-1:0]  z_in, da;
  aarm_pkg::cordic_t cor_d, cor_q;
  aarm_pkg::side_t   side_q;
  logic              valid_q;

  assign x_in = cor_i.x;
  assign y_in = cor_i.y;
  assign z_in = cor_i.z;
  assign dx   = y_in >>> STEP;
  assign dy   = x_in >>> STEP;
  assign da   = aarm_pkg::atan_deg(aarm_pkg::ATAN_IDX_W'(STEP));

  always_comb begin
    if (!z_in[aarm_pkg::ANGLE_W-1]) begin
      cor_d.x = x_in - dx;
      cor_d.y = y_in + dy;
      cor_d.z = z_in - da;
    end else begin
      cor_d.x = x_in + dx;
      cor_d.y = y_in - dy;
      cor_d.z = z_in + da;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cor_q  <= cor_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign cor_o   = cor_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

>>> sv/aarm_entry.sv
// One matrix entry: rounds t*u*v, adds or subtracts the exact term, rounds and saturates.
// Three register stages. Depends on aarm_pkg (width helpers, field limits).
`default_nettype none

module aarm_entry #(
  parameter int unsigned FRAC_BITS = aarm_pkg::FRAC_BITS_DEF,
  parameter bit          SUBTRACT  = 1'b0
) (
  input  wire                                                 clk_i,
  input  wire signed [aarm_pkg::base_width(FRAC_BITS)-1:0]    base_i,
  input  wire signed [aarm_pkg::prod_width(FRAC_BITS)-1:0]    prod_i,
  output logic signed [aarm_pkg::FIELD_W-1:0]                 entry_o
);

  localparam int PROD_W = aarm_pkg::prod_width(FRAC_BITS);
  localparam int BASE_W = aarm_pkg::base_width(FRAC_BITS);
  localparam int RND_W  = PROD_W - FRAC_BITS;
  localparam int SUM_W  = ((RND_W > BASE_W) ? RND_W : BASE_W) + 1;
  localparam int OUT_W  = SUM_W - FRAC_BITS;

  localparam logic signed [PROD_W-1:0] P_HALF = (PROD_W'(1) << FRAC_BITS) >> 1;
  localparam logic signed [SUM_W-1:0]  S_HALF = (SUM_W'(1) << FRAC_BITS) >> 1;
  localparam logic signed [OUT_W-1:0]  SAT_HI = OUT_W'(aarm_pkg::FIELD_MAX);
  localparam logic signed [OUT_W-1:0]  SAT_LO = OUT_W'(aarm_pkg::FIELD_MIN);

  logic signed [RND_W-1:0]            rnd_d, rnd_q;
  logic signed [BASE_W-1:0]           base_q;
  logic signed [SUM_W-1:0]            sum_d, sum_q;
  logic signed [OUT_W-1:0]            out_w;
  logic signed [aarm_pkg::FIELD_W-1:0] ent_d, ent_q;

  assign rnd_d = RND_W'((prod_i + P_HALF) >>> FRAC_BITS);

  always_comb begin
    if (SUBTRACT) begin
      sum_d = SUM_W'(rnd_q) - SUM_W'(base_q);
    end else begin
      sum_d = SUM_W'(rnd_q) + SUM_W'(base_q);
    end
  end

  assign out_w = OUT_W'((sum_q + S_HALF) >>> FRAC_BITS);

  always_comb begin
    if (out_w > SAT_HI) begin
      ent_d = aarm_pkg::FIELD_W'(aarm_pkg::FIELD_MAX);
    end else if (out_w < SAT_LO) begin
      ent_d = aarm_pkg::FIELD_W'(aarm_pkg::FIELD_MIN);
    end else begin
      ent_d = out_w[aarm_pkg::FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q  <= rnd_d;
    base_q <= base_i;
    sum_q  <= sum_d;
    ent_q  <= ent_d;
  end

  assign entry_o = ent_q;

endmodule

`default_nettype wire
